/* design/triangle_face_normal_assert.svh */
// Assertion macros used by the port checker
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Implication in the same cycle, off while reset is high
`define TFN_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Implication in the next cycle, off while reset is high
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

// Implication in the next cycle, active during reset as well
`define TFN_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

/* design/tfn_pkg.sv */
package tfn_pkg;

   localparam int COORD_BITS_DEF  = 16;
   localparam int INDEX_BITS_DEF  = 16;
   localparam int NORMAL_BITS_DEF = 16;
   localparam int LIMIT_BITS      = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int OUT_DEPTH       = 4;

   // cross magnitude is below 2^(2*cb+1)
   function automatic int tfn_mag_width(input int cb);
      return 2 * cb + 1;
   endfunction

   // sum of three squared magnitudes
   function automatic int tfn_len_width(input int cb);
      return 2 * tfn_mag_width(cb) + 2;
   endfunction

   // front-to-back request: indices, flag, length, signs, squares
   function automatic int tfn_queue_width(input int cb, input int ib);
      return 3 * ib + 1 + tfn_len_width(cb) + 3 * (2 * tfn_mag_width(cb) + 1);
   endfunction

endpackage

/* design/tfn_fifo.sv */
module tfn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // store incoming request
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* design/tfn_front.sv */
module tfn_front #(
   parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = tfn_pkg::INDEX_BITS_DEF,
   parameter int QW         = tfn_pkg::tfn_queue_width(COORD_BITS, INDEX_BITS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [3*INDEX_BITS-1:0]       in_index,
   input  logic signed [COORD_BITS-1:0]  in_coord [9],
   input  logic [tfn_pkg::LIMIT_BITS-1:0] limit,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [QW-1:0]                 out_data
);

   import tfn_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;
   localparam int XW = PW + 1;
   localparam int MW = tfn_mag_width(CB);
   localparam int SW = 2 * MW;
   localparam int LW = tfn_len_width(CB);

   logic [4:0]                vld_ff;
   logic                      en;
   logic [3*INDEX_BITS-1:0]   idx_ff [5];
   logic signed [DW-1:0]      d_ff [6];
   logic signed [PW-1:0]      p_ff [6];
   logic [MW-1:0]             mag_ff [3];
   logic [2:0]                neg3_ff, neg4_ff, neg5_ff;
   logic [SW-1:0]             sq_ff [3];
   logic [SW-1:0]             sq5_ff [3];
   logic [LW-1:0]             len_ff;
   logic                      degen_ff;
   logic [LW-1:0]             len_in;

   assign en        = !vld_ff[4] || out_ready;
   assign in_ready  = en;
   assign out_valid = vld_ff[4];
   assign out_data  = {idx_ff[4], degen_ff, len_ff, neg5_ff, sq5_ff[2], sq5_ff[1], sq5_ff[0]};

   assign len_in = LW'(sq_ff[0]) + LW'(sq_ff[1]) + LW'(sq_ff[2]);

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // edge vectors, products, cross terms, squares, length
   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff[0] <= in_index;
         for (int i = 1; i < 5; i++) begin
            idx_ff[i] <= idx_ff[i-1];
         end
         for (int i = 0; i < 3; i++) begin
            d_ff[i]   <= DW'(in_coord[3+i]) - DW'(in_coord[i]);
            d_ff[3+i] <= DW'(in_coord[6+i]) - DW'(in_coord[i]);
         end
         // d_ff: 0..2 edge ab (x,y,z), 3..5 edge ac
         p_ff[0] <= PW'(d_ff[1]) * PW'(d_ff[5]);
         p_ff[1] <= PW'(d_ff[2]) * PW'(d_ff[4]);
         p_ff[2] <= PW'(d_ff[2]) * PW'(d_ff[3]);
         p_ff[3] <= PW'(d_ff[0]) * PW'(d_ff[5]);
         p_ff[4] <= PW'(d_ff[0]) * PW'(d_ff[4]);
         p_ff[5] <= PW'(d_ff[1]) * PW'(d_ff[3]);
         for (int i = 0; i < 3; i++) begin
            logic signed [XW-1:0] c;
            c = XW'(p_ff[2*i]) - XW'(p_ff[2*i+1]);
            neg3_ff[i] <= c[XW-1];
            mag_ff[i]  <= c[XW-1] ? MW'(-c) : MW'(c);
            sq_ff[i]   <= SW'(mag_ff[i]) * SW'(mag_ff[i]);
            sq5_ff[i]  <= sq_ff[i];
         end
         neg4_ff  <= neg3_ff;
         neg5_ff  <= neg4_ff;
         len_ff   <= len_in;
         degen_ff <= (len_in <= LW'(limit));
      end
   end

endmodule

/* design/tfn_back.sv */
module tfn_back #(
   parameter int COORD_BITS  = tfn_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS  = tfn_pkg::INDEX_BITS_DEF,
   parameter int NORMAL_BITS = tfn_pkg::NORMAL_BITS_DEF,
   parameter int QW          = tfn_pkg::tfn_queue_width(COORD_BITS, INDEX_BITS),
   parameter int OW          = 3 * INDEX_BITS + 3 * NORMAL_BITS + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_pop,
   input  logic [QW-1:0] in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [OW-1:0] out_data
);

   import tfn_pkg::*;

   localparam int FB  = NORMAL_BITS - 1;
   localparam int MW  = tfn_mag_width(COORD_BITS);
   localparam int SW  = 2 * MW;
   localparam int LW  = tfn_len_width(COORD_BITS);
   localparam int RW  = LW + 2 * FB + 1;
   localparam int PLW = LW + FB;
   localparam int IB  = INDEX_BITS;
   localparam int NB  = NORMAL_BITS;

   logic [FB:0]             vld_ff;
   logic                    en;
   logic [RW-1:0]           r_ff   [FB+1][3];
   logic [PLW-1:0]          p_ff   [FB+1][3];
   logic [FB-1:0]           q_ff   [FB+1][3];
   logic [LW-1:0]           len_ff [FB+1];
   logic [2:0]              neg_ff [FB+1];
   logic                    dg_ff  [FB+1];
   logic [3*IB-1:0]         idx_ff [FB+1];
   logic [SW-1:0]           sq_in  [3];
   logic [NB-1:0]           nrm    [3];

   assign en        = !vld_ff[FB] || out_ready;
   assign in_pop    = en && in_valid;
   assign out_valid = vld_ff[FB];

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign sq_in[i] = in_data[i*SW +: SW];
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FB-1:0], in_valid};
      end
   end

   // load remainder with squared component scaled by 2^(2*FB)
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            r_ff[0][i] <= RW'(sq_in[i]) << (2 * FB);
            p_ff[0][i] <= '0;
            q_ff[0][i] <= '0;
         end
         neg_ff[0] <= in_data[3*SW +: 3];
         len_ff[0] <= in_data[3*SW+3 +: LW];
         dg_ff[0]  <= in_data[3*SW+3+LW];
         idx_ff[0] <= in_data[3*SW+4+LW +: 3*IB];
      end
   end

   // one quotient bit per stage: keep q^2*len at or below the scaled square
   for (genvar s = 0; s < FB; s++) begin : g_step
      localparam int B = FB - 1 - s;
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               logic [RW-1:0] d;
               d = (RW'(p_ff[s][i]) << (B + 1)) + (RW'(len_ff[s]) << (2 * B));
               if (d <= r_ff[s][i]) begin
                  r_ff[s+1][i] <= r_ff[s][i] - d;
                  p_ff[s+1][i] <= p_ff[s][i] + (PLW'(len_ff[s]) << B);
                  q_ff[s+1][i] <= q_ff[s][i] | (FB'(1) << B);
               end else begin
                  r_ff[s+1][i] <= r_ff[s][i];
                  p_ff[s+1][i] <= p_ff[s][i];
                  q_ff[s+1][i] <= q_ff[s][i];
               end
            end
            len_ff[s+1] <= len_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            dg_ff[s+1]  <= dg_ff[s];
            idx_ff[s+1] <= idx_ff[s];
         end
      end
   end

   // apply sign, drop to zero for degenerate triangles
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dg_ff[FB]) begin
            nrm[i] = '0;
         end else if (neg_ff[FB][i]) begin
            nrm[i] = -NB'(q_ff[FB][i]);
         end else begin
            nrm[i] = NB'(q_ff[FB][i]);
         end
      end
   end

   // reversed winding: third, second, first
   assign out_data = {idx_ff[FB][IB-1:0], idx_ff[FB][2*IB-1:IB], idx_ff[FB][3*IB-1:2*IB],
                      nrm[0], nrm[1], nrm[2], dg_ff[FB]};

endmodule

/* design/triangle_face_normal.sv */
// From accepted request to result: five front stages, one queue slot, NORMAL_BITS
// back stages, one output slot. Throughput: one triangle per cycle unless a full
// queue stalls the pipeline; the back part resolves one normal bit per stage in a
// pipelined restoring recurrence, one stage per quotient bit.
// Reset (synchronous, active high) empties both queues and all pipeline stages
// and sets degenerate_limit to 0.
module triangle_face_normal #(
   parameter int COORD_BITS  = tfn_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS  = tfn_pkg::INDEX_BITS_DEF,
   parameter int NORMAL_BITS = tfn_pkg::NORMAL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tfn_pkg::LIMIT_BITS-1:0] csr_wr_data,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [INDEX_BITS-1:0]          req_first_index,
   input  logic [INDEX_BITS-1:0]          req_second_index,
   input  logic [INDEX_BITS-1:0]          req_third_index,
   input  logic signed [COORD_BITS-1:0]   req_vertex_a_x,
   input  logic signed [COORD_BITS-1:0]   req_vertex_a_y,
   input  logic signed [COORD_BITS-1:0]   req_vertex_a_z,
   input  logic signed [COORD_BITS-1:0]   req_vertex_b_x,
   input  logic signed [COORD_BITS-1:0]   req_vertex_b_y,
   input  logic signed [COORD_BITS-1:0]   req_vertex_b_z,
   input  logic signed [COORD_BITS-1:0]   req_vertex_c_x,
   input  logic signed [COORD_BITS-1:0]   req_vertex_c_y,
   input  logic signed [COORD_BITS-1:0]   req_vertex_c_z,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [INDEX_BITS-1:0]          rsp_out_first_index,
   output logic [INDEX_BITS-1:0]          rsp_out_second_index,
   output logic [INDEX_BITS-1:0]          rsp_out_third_index,
   output logic signed [NORMAL_BITS-1:0]  rsp_normal_x,
   output logic signed [NORMAL_BITS-1:0]  rsp_normal_y,
   output logic signed [NORMAL_BITS-1:0]  rsp_normal_z,
   output logic                           rsp_degenerate
);

   import tfn_pkg::*;

   localparam int QW = tfn_queue_width(COORD_BITS, INDEX_BITS);
   localparam int IB = INDEX_BITS;
   localparam int NB = NORMAL_BITS;
   localparam int OW = 3 * IB + 3 * NB + 1;

   logic [LIMIT_BITS-1:0]        limit_ff;
   logic signed [COORD_BITS-1:0] coord [9];
   logic                         f_valid, f_ready, f_in_ready;
   logic [QW-1:0]                f_data, q_data;
   logic                         q_full, q_empty, b_pop;
   logic                         b_valid, o_full;
   logic [OW-1:0]                b_data, o_data;

   // hold the degenerate limit
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign coord[0] = req_vertex_a_x;
   assign coord[1] = req_vertex_a_y;
   assign coord[2] = req_vertex_a_z;
   assign coord[3] = req_vertex_b_x;
   assign coord[4] = req_vertex_b_y;
   assign coord[5] = req_vertex_b_z;
   assign coord[6] = req_vertex_c_x;
   assign coord[7] = req_vertex_c_y;
   assign coord[8] = req_vertex_c_z;

   assign req_full = !f_in_ready;
   assign f_ready  = !q_full;

   tfn_front #(
      .COORD_BITS(COORD_BITS),
      .INDEX_BITS(INDEX_BITS),
      .QW(QW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_push),
      .in_ready(f_in_ready),
      .in_index({req_first_index, req_second_index, req_third_index}),
      .in_coord(coord),
      .limit(limit_ff),
      .out_valid(f_valid),
      .out_ready(f_ready),
      .out_data(f_data)
   );

   tfn_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(f_valid),
      .push_data(f_data),
      .full(q_full),
      .pop(b_pop),
      .empty(q_empty),
      .pop_data(q_data)
   );

   tfn_back #(
      .COORD_BITS(COORD_BITS),
      .INDEX_BITS(INDEX_BITS),
      .NORMAL_BITS(NORMAL_BITS),
      .QW(QW),
      .OW(OW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(!q_empty),
      .in_pop(b_pop),
      .in_data(q_data),
      .out_valid(b_valid),
      .out_ready(!o_full),
      .out_data(b_data)
   );

   tfn_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out (
      .clock(clock),
      .reset(reset),
      .push(b_valid),
      .push_data(b_data),
      .full(o_full),
      .pop(rsp_pop),
      .empty(rsp_empty),
      .pop_data(o_data)
   );

   assign rsp_degenerate       = o_data[0];
   assign rsp_normal_z         = o_data[1 +: NB];
   assign rsp_normal_y         = o_data[1+NB +: NB];
   assign rsp_normal_x         = o_data[1+2*NB +: NB];
   assign rsp_out_third_index  = o_data[1+3*NB +: IB];
   assign rsp_out_second_index = o_data[1+3*NB+IB +: IB];
   assign rsp_out_first_index  = o_data[1+3*NB+2*IB +: IB];

endmodule

/* design/tfn_checker.sv */
`include "triangle_face_normal_assert.svh"

module tfn_port_checker #(
   parameter int NORMAL_BITS = tfn_pkg::NORMAL_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic signed [NORMAL_BITS-1:0] rsp_normal_x,
   input logic signed [NORMAL_BITS-1:0] rsp_normal_y,
   input logic signed [NORMAL_BITS-1:0] rsp_normal_z,
   input logic                          rsp_degenerate
);

   localparam logic [NORMAL_BITS-1:0] MOST_NEG = {1'b1, {(NORMAL_BITS-1){1'b0}}};

   logic normal_zero;
   logic no_most_neg;

   assign normal_zero = (rsp_normal_x == '0) && (rsp_normal_y == '0) && (rsp_normal_z == '0);
   assign no_most_neg = (rsp_normal_x != MOST_NEG) && (rsp_normal_y != MOST_NEG)
                        && (rsp_normal_z != MOST_NEG);

   // reset leaves no result waiting and the input open
   `TFN_ASSERT_RST(a_reset_clears, reset, rsp_empty && !req_full)

   // degenerate triangles carry a zero normal
   `TFN_ASSERT_IMPL(a_degen_zero, !rsp_empty && rsp_degenerate, normal_zero)

   // components saturate symmetrically, never the most negative code
   `TFN_ASSERT_IMPL(a_no_most_neg, !rsp_empty, no_most_neg)

   // a waiting result holds until taken
   `TFN_ASSERT_NEXT(a_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_normal_x) && $stable(rsp_degenerate))

endmodule

bind triangle_face_normal tfn_port_checker #(.NORMAL_BITS(NORMAL_BITS)) u_tfn_checker (.*);
